// ===== rtl/rcr_pkg.sv =====
// Package: shared types and constants for the 3x3 RGB convolution block.
package rcr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KERNEL_SIZE_DEF = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PIX_W = 24;
    localparam int ROW_W = 16;
    localparam int COL_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KTOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KMID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KBOT = 3'd4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [15:0] out_row;
        logic [9:0] out_col;
        logic last_of_run;
    } pix_out_t;

    typedef logic [PIX_W-1:0] win_t [9];

    // one output job: which window rows and columns feed each kernel offset
    typedef struct packed {
        logic [1:0] r0;
        logic [1:0] r1;
        logic [1:0] r2;
        logic [1:0] c0;
        logic [1:0] c1;
        logic [15:0] row;
        logic [9:0] col;
        logic last;
    } job_t;

endpackage

// ===== rtl/rcr_ram.sv =====
// Generic single-port write, single-port registered read RAM.
module rcr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/rcr_mac.sv =====
// Kernel datapath: nine taps per channel, registered products, sum, truncate, saturate.
module rcr_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                advance,
    input  logic [23:0]         taps [9],
    input  logic [47:0]         krow [3],
    input  rcr_pkg::job_t       job,
    output logic                out_valid,
    output rcr_pkg::pix_out_t   out_data
);
    // stage 1: products
    logic signed [24:0] prod_reg [3][9];
    logic signed [24:0] prod_next [3][9];
    logic p_valid_reg;
    rcr_pkg::job_t pjob_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int t = 0; t < 9; t++)
            begin
                prod_next[ch][t] = $signed({1'b0, taps[t][8*ch +: 8]})
                    * $signed(krow[2 - t/3][16*(2 - t%3) +: 16]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            pjob_reg <= job;
        end
    end

    logic [7:0] chan [3];
    always_comb
    begin
        logic signed [28:0] s;
        for (int ch = 0; ch < 3; ch++)
        begin
            s = '0;
            for (int t = 0; t < 9; t++)
            begin
                s = s + 29'(prod_reg[ch][t]);
            end
            if (s <= 0)
                chan[ch] = 8'd0;
            else if (s[28:12] > 17'd255)
                chan[ch] = 8'd255;
            else
                chan[ch] = s[19:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data.red_out <= chan[0];
            out_data.green_out <= chan[1];
            out_data.blue_out <= chan[2];
            out_data.out_row <= pjob_reg.row;
            out_data.out_col <= pjob_reg.col;
            out_data.last_of_run <= pjob_reg.last;
        end
    end
endmodule

// ===== rtl/rgb_convolution_3x3_reflect.sv =====
// Top level: streaming 3x3 RGB convolution with reflected borders.
// Pixels enter in raster order; each pixel causes zero to four outputs, which take turns
// in the shared kernel datapath, one per cycle while the output is not stalled. A pixel
// waits in stage A, where the line store is read, until stage B has issued the jobs of
// the pixel ahead of it; the kernel datapath then registers the products and then the
// summed and saturated result before it appears at the output.
module rgb_convolution_3x3_reflect #(
    parameter int MAX_WIDTH = rcr_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE = rcr_pkg::KERNEL_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rcr_pkg::pix_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rcr_pkg::pix_out_t               out_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int KS = KERNEL_SIZE;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [47:0] krow_reg [KS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 16'd1024;
            krow_reg[0] <= '0;
            krow_reg[1] <= 48'h10000000;
            krow_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcr_pkg::REG_WIDTH:  width_reg <= cfg_data[10:0];
                rcr_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                rcr_pkg::REG_KTOP:   krow_reg[0] <= cfg_data;
                rcr_pkg::REG_KMID:   krow_reg[1] <= cfg_data;
                rcr_pkg::REG_KBOT:   krow_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [12:0] w_eff;
    logic [15:0] h_eff;
    always_comb
    begin
        w_eff = {2'b0, width_reg};
        if (width_reg < 11'd2) w_eff = 13'd2;
        if ({2'b0, width_reg} > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
        h_eff = (height_reg < 16'd2) ? 16'd2 : height_reg;
    end

    // output flow control and datapath advance
    logic mac_valid;
    rcr_pkg::pix_out_t mac_data;
    logic advance;
    assign advance = !out_valid || out_ready;

    // stage A: accepted pixel, line store read in flight
    logic a_valid_reg;
    rcr_pkg::pix_in_t a_pix_reg;
    logic [12:0] a_x_reg;
    logic [15:0] a_y_reg;
    logic [12:0] x_reg;
    logic [15:0] y_reg;
    logic [AW-1:0] idx;

    // stage B: window shifted, jobs being issued
    logic b_busy_reg;
    logic [2:0] b_n_reg;
    logic [2:0] b_k_reg;
    rcr_pkg::job_t b_jobs_reg [4];
    logic [23:0] win_reg [9];

    logic b_done;
    assign b_done = !b_busy_reg || (advance && (b_k_reg + 3'd1 >= b_n_reg));
    logic a_move;
    assign a_move = a_valid_reg && b_done;
    assign in_ready = !a_valid_reg || b_done;
    logic acc;
    assign acc = in_valid && in_ready;

    assign idx = (x_reg < 13'(MAX_WIDTH)) ? x_reg[AW-1:0] : AW'(MAX_WIDTH - 1);

    logic [23:0] up_rd, lo_rd;
    logic [AW-1:0] a_idx_reg;
    rcr_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(a_move), .waddr(a_idx_reg), .wdata(lo_rd),
        .re(acc), .raddr(idx), .rdata(up_rd));
    rcr_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower (
        .clk(clk), .we(a_move), .waddr(a_idx_reg), .wdata(a_pix_reg),
        .re(acc), .raddr(idx), .rdata(lo_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                if (x_reg >= w_eff - 13'd1)
                begin
                    x_reg <= '0;
                    y_reg <= (y_reg >= h_eff - 16'd1) ? 16'd0 : y_reg + 16'd1;
                end
                else
                begin
                    x_reg <= x_reg + 13'd1;
                end
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_pix_reg <= in_data;
            a_x_reg <= x_reg;
            a_y_reg <= y_reg;
            a_idx_reg <= idx;
        end
    end

    // build job list for the pixel in stage A
    rcr_pkg::job_t jobs [4];
    logic [2:0] njobs;
    always_comb
    begin
        logic right, last;
        logic [1:0] cs0 [2];
        logic [1:0] cs1 [2];
        logic [9:0] cp [2];
        logic [1:0] nc;
        right = a_x_reg >= w_eff - 13'd1;
        last = a_y_reg >= h_eff - 16'd1;
        nc = 2'd0;
        cs0[0] = 2'd0; cs1[0] = 2'd1; cp[0] = '0;
        cs0[1] = 2'd0; cs1[1] = 2'd1; cp[1] = '0;
        for (int q = 0; q < 4; q++) jobs[q] = '0;
        if (a_x_reg >= 13'd1)
        begin
            cs0[0] = (a_x_reg == 13'd1) ? 2'd1 : 2'd0;
            cs1[0] = 2'd1;
            cp[0] = 10'(a_x_reg - 13'd1);
            nc = 2'd1;
        end
        if (right)
        begin
            cs0[nc[0]] = 2'd1;
            cs1[nc[0]] = 2'd2;
            cp[nc[0]] = a_x_reg[9:0];
            nc = nc + 2'd1;
        end
        njobs = 3'd0;
        if (a_y_reg >= 16'd1)
        begin
            for (int s = 0; s < 2; s++)
            begin
                if (2'(s) < nc)
                begin
                    jobs[njobs[1:0]].r0 = (a_y_reg == 16'd1) ? 2'd1 : 2'd0;
                    jobs[njobs[1:0]].r1 = 2'd1;
                    jobs[njobs[1:0]].r2 = 2'd2;
                    jobs[njobs[1:0]].c0 = cs0[s];
                    jobs[njobs[1:0]].c1 = cs1[s];
                    jobs[njobs[1:0]].row = a_y_reg - 16'd1;
                    jobs[njobs[1:0]].col = cp[s];
                    njobs = njobs + 3'd1;
                    if (last)
                    begin
                        jobs[njobs[1:0]].r0 = 2'd1;
                        jobs[njobs[1:0]].r1 = 2'd2;
                        jobs[njobs[1:0]].r2 = 2'd2;
                        jobs[njobs[1:0]].c0 = cs0[s];
                        jobs[njobs[1:0]].c1 = cs1[s];
                        jobs[njobs[1:0]].row = a_y_reg;
                        jobs[njobs[1:0]].col = cp[s];
                        njobs = njobs + 3'd1;
                    end
                end
            end
        end
        if (njobs != 3'd0) jobs[njobs[1:0] - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_busy_reg <= 1'b0;
            b_k_reg <= '0;
            b_n_reg <= '0;
            for (int t = 0; t < 9; t++) win_reg[t] <= '0;
        end
        else if (a_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3] <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= up_rd;
            win_reg[5] <= lo_rd;
            win_reg[8] <= a_pix_reg;
            b_busy_reg <= njobs != 3'd0;
            b_n_reg <= njobs;
            b_k_reg <= '0;
        end
        else if (b_busy_reg && advance)
        begin
            b_k_reg <= b_k_reg + 3'd1;
            if (b_k_reg + 3'd1 >= b_n_reg) b_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move) b_jobs_reg <= jobs;
    end

    // select taps for the current job
    rcr_pkg::job_t cj;
    logic [23:0] taps [9];
    always_comb
    begin
        logic [1:0] rr [3];
        logic [1:0] cc [3];
        cj = b_jobs_reg[b_k_reg[1:0]];
        rr[0] = cj.r0; rr[1] = cj.r1; rr[2] = cj.r2;
        cc[0] = cj.c0; cc[1] = cj.c1; cc[2] = 2'd2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                taps[i*3+j] = win_reg[4'(rr[i]) * 4'd3 + 4'(cc[j])];
    end

    rcr_mac u_mac (
        .clk(clk), .rst_n(rst_n), .in_valid(b_busy_reg), .advance(advance),
        .taps(taps), .krow(krow_reg), .job(cj),
        .out_valid(mac_valid), .out_data(mac_data));

    assign out_valid = mac_valid;
    assign out_data = mac_data;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_done) |-> !in_ready)
        else $error("input taken while jobs pending");
    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        b_busy_reg |-> (b_k_reg < b_n_reg && b_n_reg <= 3'd4))
        else $error("job index out of range");
endmodule

// ===== tb/testbench.sv =====
// Testbench for the streaming 3x3 RGB convolution with reflected borders.
`timescale 1ns / 100ps

module testbench;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rcr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    rcr_pkg::pix_in_t in_data;
    logic out_valid;
    logic out_ready;
    rcr_pkg::pix_out_t out_data;

    rgb_convolution_3x3_reflect u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    localparam int LINE_DEPTH = 1024;
    localparam int IDLE_LIMIT = 20000;

    // configuration and state of the expected-pixel model
    logic [10:0] geo_width;
    logic [15:0] geo_height;
    logic [47:0] kernel_row [3];
    logic [23:0] line_upper [LINE_DEPTH];
    logic [23:0] line_lower [LINE_DEPTH];
    logic [23:0] taps [9];
    int unsigned col_pos;
    int unsigned row_pos;

    rcr_pkg::pix_in_t pixel_q [$];
    rcr_pkg::pix_out_t conv_q [$];

    int mismatches = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int idle_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int ready_phase = 0;
    int burst_left = 0;
    int gap_left = 0;

    always #2 clk = ~clk;

    function automatic logic [7:0] conv_channel(int ch, int rsel [3], int csel [3]);
        longint acc;
        logic [15:0] raw;
        logic [7:0] p;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = taps[rsel[i] * 3 + csel[j]][8 * ch +: 8];
                raw = kernel_row[2 - i][16 * (2 - j) +: 16];
                acc += longint'(p) * longint'($signed(raw));
            end
        end
        if (acc <= 0)
            return 8'd0;
        acc = acc >>> 12;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic void push_conv(int rsel [3], int csel [3], int unsigned r,
                                      int unsigned c);
        rcr_pkg::pix_out_t o;
        o.red_out = conv_channel(0, rsel, csel);
        o.green_out = conv_channel(1, rsel, csel);
        o.blue_out = conv_channel(2, rsel, csel);
        o.out_row = r[15:0];
        o.out_col = c[9:0];
        o.last_of_run = 1'b0;
        conv_q.push_back(o);
    endfunction

    function automatic void predict_conv(rcr_pkg::pix_in_t px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        int unsigned cpos [2];
        int csets [2][3];
        int up_rows [3];
        int last_rows [3];
        int ncols;
        int start;
        bit right;
        bit last;
        w = geo_width;
        h = geo_height;
        if (w < 2) w = 2;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < 2) h = 2;
        x = col_pos;
        y = row_pos;
        idx = (x < LINE_DEPTH) ? x : LINE_DEPTH - 1;
        for (int r = 0; r < 3; r++) begin
            taps[r * 3] = taps[r * 3 + 1];
            taps[r * 3 + 1] = taps[r * 3 + 2];
        end
        taps[2] = line_upper[idx];
        taps[5] = line_lower[idx];
        taps[8] = {px.blue, px.green, px.red};
        line_upper[idx] = line_lower[idx];
        line_lower[idx] = {px.blue, px.green, px.red};
        right = x >= w - 1;
        last = y >= h - 1;
        ncols = 0;
        if (x >= 1) begin
            csets[ncols] = '{(x == 1) ? 1 : 0, 1, 2};
            cpos[ncols] = x - 1;
            ncols++;
        end
        if (right) begin
            csets[ncols] = '{1, 2, 2};
            cpos[ncols] = x;
            ncols++;
        end
        start = conv_q.size();
        if (y >= 1) begin
            up_rows = '{(y == 1) ? 1 : 0, 1, 2};
            last_rows = '{1, 2, 2};
            for (int s = 0; s < ncols; s++) begin
                push_conv(up_rows, csets[s], y - 1, cpos[s]);
                if (last)
                    push_conv(last_rows, csets[s], y, cpos[s]);
            end
        end
        if (conv_q.size() > start)
            conv_q[conv_q.size() - 1].last_of_run = 1'b1;
        if (right) begin
            col_pos = 0;
            row_pos = last ? 0 : ((y + 1) & 16'hFFFF);
        end
        else begin
            col_pos = x + 1;
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_conv(in_data);
                pixels_sent++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= pixel_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: own stall pattern plus requested long hold-offs
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = 400;
            out_ready <= 1'b0;
        end
        else begin
            ready_phase = (ready_phase + 1) % 150;
            if (ready_phase < 50)
                out_ready <= 1'b1;
            else if (ready_phase < 100)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // check each output transfer against the oldest expected pixel
    always @(posedge clk) begin
        rcr_pkg::pix_out_t exp_px;
        if (rst_n && out_valid && out_ready) begin
            if (conv_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: %p", out_data);
            end
            else begin
                exp_px = conv_q.pop_front();
                pixels_checked++;
                if (out_data !== exp_px) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_px, out_data);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [rcr_pkg::CFG_IDX_W-1:0] idx,
                             logic [rcr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            rcr_pkg::REG_WIDTH: geo_width = val[10:0];
            rcr_pkg::REG_HEIGHT: geo_height = val[15:0];
            rcr_pkg::REG_KTOP: kernel_row[0] = val;
            rcr_pkg::REG_KMID: kernel_row[1] = val;
            rcr_pkg::REG_KBOT: kernel_row[2] = val;
            default: ;
        endcase
    endtask

    task automatic setup(int w, int h, logic [47:0] kt, logic [47:0] km, logic [47:0] kb);
        write_reg(rcr_pkg::REG_WIDTH, 48'(w));
        write_reg(rcr_pkg::REG_HEIGHT, 48'(h));
        write_reg(rcr_pkg::REG_KTOP, kt);
        write_reg(rcr_pkg::REG_KMID, km);
        write_reg(rcr_pkg::REG_KBOT, kb);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !in_valid);
        wait (conv_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_random(int n);
        rcr_pkg::pix_in_t px;
        for (int i = 0; i < n; i++) begin
            px = 24'($urandom);
            pixel_q.push_back(px);
        end
    endtask

    function automatic logic [47:0] rand_kernel_row();
        logic [47:0] k;
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 3))
                0: k[16 * j +: 16] = 16'($urandom);
                1: k[16 * j +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
                2: k[16 * j +: 16] = 16'h0800;
                default: k[16 * j +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
            endcase
        end
        return k;
    endfunction

    initial begin
        int w;
        int h;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        geo_width = 11'd1024;
        geo_height = 16'd1024;
        kernel_row[0] = '0;
        kernel_row[1] = 48'h0000_1000_0000;
        kernel_row[2] = '0;
        foreach (taps[i]) taps[i] = '0;
        foreach (line_upper[i]) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // identity kernel, extreme pixel values
        setup(4, 3, 48'h0, 48'h0000_1000_0000, 48'h0);
        for (int i = 0; i < 12; i++)
            pixel_q.push_back((i % 3 == 0) ? 24'hFFFFFF : (i % 3 == 1) ? 24'h000000 :
                              24'h5AA5C3);
        drain();

        // extreme coefficients, saturation both ways
        setup(3, 2, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_0001, 48'hFFFF_0000_7FFF);
        for (int i = 0; i < 6; i++)
            pixel_q.push_back((i % 2) ? 24'hFFFFFF : 24'h010203);
        drain();

        // width and height below two are clamped
        setup(1, 0, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        pixel_q.push_back(24'hFF00FF);
        pixel_q.push_back(24'h00FF00);
        pixel_q.push_back(24'h123456);
        pixel_q.push_back(24'hFEDCBA);
        drain();

        // random frames; the first is held off at the output for a long stretch
        for (int f = 0; f < 8; f++) begin
            w = (f == 0) ? 9 : $urandom_range(2, 9);
            h = (f == 0) ? 4 : $urandom_range(2, 4);
            setup(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
            if (f == 0)
                hold_requests++;
            send_random(w);
            wait (pixel_q.size() == 0 && !in_valid);
            wait (conv_q.size() == 0);
            send_random(w * (h - 1));
            drain();
        end

        // tallest frame, cut short by lowering the height mid-frame
        setup(2, 65535, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        send_random(8);
        drain();
        setup(2, 2, rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        send_random(2);
        drain();

        $display("Covered %0d pixels in and %0d results out over clamped, small, random",
                 pixels_sent, pixels_checked);
        $display("and cut-short frames with extreme and random kernels.");
        if (mismatches == 0 && conv_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
